>>> rtl/iiws_pkg.sv
// Shared types and constants of the integral image block with squared sums.
// No dependencies; iiws_front, iiws_back and the top level import this package.
package iiws_pkg;

   localparam int PIXEL_W     = 8;
   localparam int SQ_PIXEL_W  = 16;
   localparam int SIZE_W      = 11;
   localparam int AREA_W      = 28;
   localparam int SQUARE_W    = 36;
   localparam int ABOVE_SQ_W  = 37;
   localparam int ROW_W       = 18;
   localparam int ROW_SQ_W    = 26;
   localparam int CSR_INDEX_W = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH) + 1;

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd480;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic                first_row;
      logic                last;
      logic [ROW_W-1:0]    row_sum;
      logic [ROW_SQ_W-1:0] row_square_sum;
   } work_type;

   typedef struct packed {
      logic [AREA_W-1:0]   area_sum;
      logic [SQUARE_W-1:0] square_sum;
      logic                frame_end;
   } result_type;

endpackage

>>> rtl/iiws_fifo.sv
// Small register queue used between front and back and at the result side.
// Depends on nothing; DEPTH must be a power of two.
module iiws_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PtrW = $clog2(DEPTH),
   localparam int CountW = PtrW + 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [WIDTH-1:0]  data_in,
   input  logic              pop,
   output logic [WIDTH-1:0]  data_out,
   output logic              full,
   output logic              empty,
   output logic [CountW-1:0] count
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PtrW:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW:0]    rd_ptr_ff, rd_ptr_in;
   logic             do_push, do_pop;

   always_comb begin
      count     = CountW'(wr_ptr_ff - rd_ptr_ff);
      full      = (count == CountW'(DEPTH));
      empty     = (count == '0);
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      data_out  = mem_ff[rd_ptr_ff[PtrW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff[PtrW-1:0]] <= data_in;
      end
   end

endmodule

>>> rtl/iiws_front.sv
// Front part: size registers, column and row counters, running row sums.
// Classifies each pixel word (first row, frame end). Uses iiws_pkg.
module iiws_front import iiws_pkg::*; #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HEIGHT = 1024,
   localparam int ColW = $clog2(MAX_WIDTH),
   localparam int RowW = $clog2(MAX_HEIGHT)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]      csr_data,
   input  logic                   push,
   input  logic [PIXEL_W-1:0]     pixel,
   input  logic                   queue_full,
   output logic                   queue_push,
   output logic [ColW-1:0]        work_col,
   output work_type               work
);

   localparam int WW = ($clog2(MAX_WIDTH + 1) > SIZE_W) ? $clog2(MAX_WIDTH + 1) : SIZE_W;
   localparam int HW = ($clog2(MAX_HEIGHT + 1) > SIZE_W) ? $clog2(MAX_HEIGHT + 1) : SIZE_W;

   logic [SIZE_W-1:0]     width_ff, height_ff;
   logic [ColW-1:0]       col_ff, col_in;
   logic [RowW-1:0]       row_ff, row_in;
   logic [ROW_W-1:0]      row_sum_ff, row_sum_in;
   logic [ROW_SQ_W-1:0]   row_sq_ff, row_sq_in;
   logic [WW-1:0]         width_use, col_next;
   logic [HW-1:0]         height_use, row_next;
   logic [SQ_PIXEL_W-1:0] pixel_sq;
   logic [ROW_W-1:0]      sum_next;
   logic [ROW_SQ_W-1:0]   sq_next;
   logic                  accept, row_end, last;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH: begin
               width_ff <= csr_data;
            end
            CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         width_use = WW'(1);
      end else if (WW'(width_ff) > WW'(MAX_WIDTH)) begin
         width_use = WW'(MAX_WIDTH);
      end else begin
         width_use = WW'(width_ff);
      end
      if (height_ff == '0) begin
         height_use = HW'(1);
      end else if (HW'(height_ff) > HW'(MAX_HEIGHT)) begin
         height_use = HW'(MAX_HEIGHT);
      end else begin
         height_use = HW'(height_ff);
      end

      accept   = push && !queue_full;
      pixel_sq = SQ_PIXEL_W'(pixel) * SQ_PIXEL_W'(pixel);
      sum_next = row_sum_ff + ROW_W'(pixel);
      sq_next  = row_sq_ff + ROW_SQ_W'(pixel_sq);
      col_next = WW'(col_ff) + WW'(1);
      row_next = HW'(row_ff) + HW'(1);
      row_end  = (col_next >= width_use);
      last     = row_end && (row_next >= height_use);

      col_in     = col_ff;
      row_in     = row_ff;
      row_sum_in = row_sum_ff;
      row_sq_in  = row_sq_ff;
      if (accept) begin
         if (row_end) begin
            col_in     = '0;
            row_sum_in = '0;
            row_sq_in  = '0;
            row_in     = last ? '0 : RowW'(row_ff + RowW'(1));
         end else begin
            col_in     = ColW'(col_ff + ColW'(1));
            row_sum_in = sum_next;
            row_sq_in  = sq_next;
         end
      end

      queue_push          = accept;
      work_col            = col_ff;
      work.first_row      = (row_ff == '0);
      work.last           = last;
      work.row_sum        = sum_next;
      work.row_square_sum = sq_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         row_sum_ff <= '0;
         row_sq_ff  <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         row_sum_ff <= row_sum_in;
         row_sq_ff  <= row_sq_in;
      end
   end

endmodule

>>> rtl/iiws_back.sv
// Back part: line stores of the previous row's sums, add and write back.
// Issues a word only with room in the result queue. Uses iiws_pkg.
module iiws_back import iiws_pkg::*; #(
   parameter int MAX_WIDTH = 1024,
   localparam int ColW = $clog2(MAX_WIDTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  logic [ColW-1:0]     queue_col,
   input  work_type            queue_work,
   output logic                queue_pop,
   input  logic [QCOUNT_W-1:0] out_count,
   output logic                out_push,
   output result_type          out_data
);

   logic [AREA_W-1:0]     area_mem [MAX_WIDTH];
   logic [ABOVE_SQ_W-1:0] sq_mem [MAX_WIDTH];

   logic                  s1_valid_ff;
   work_type              s1_work_ff;
   logic [ColW-1:0]       s1_col_ff;
   logic [AREA_W-1:0]     rd_area_ff, byp_area_ff, up_area, area_now;
   logic [ABOVE_SQ_W-1:0] rd_sq_ff, byp_sq_ff, up_sq, sq_now;
   logic                  byp_ff, issue;

   always_comb begin
      issue = !queue_empty
              && ((out_count + QCOUNT_W'(s1_valid_ff)) < QCOUNT_W'(QUEUE_DEPTH));
      queue_pop = issue;

      if (s1_work_ff.first_row) begin
         up_area = '0;
         up_sq   = '0;
      end else if (byp_ff) begin
         up_area = byp_area_ff;
         up_sq   = byp_sq_ff;
      end else begin
         up_area = rd_area_ff;
         up_sq   = rd_sq_ff;
      end
      area_now = AREA_W'(s1_work_ff.row_sum) + up_area;
      sq_now   = ABOVE_SQ_W'(s1_work_ff.row_square_sum) + up_sq;

      out_push            = s1_valid_ff;
      out_data.area_sum   = area_now;
      out_data.square_sum = sq_now[SQUARE_W-1:0];
      out_data.frame_end  = s1_work_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
      end
   end

   // forward the entry written this cycle to a word that reads it now
   always_ff @(posedge clock) begin
      if (issue) begin
         s1_work_ff  <= queue_work;
         s1_col_ff   <= queue_col;
         byp_ff      <= s1_valid_ff && (s1_col_ff == queue_col);
         byp_area_ff <= area_now;
         byp_sq_ff   <= sq_now;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_area_ff <= area_mem[queue_col];
         rd_sq_ff   <= sq_mem[queue_col];
      end
      if (s1_valid_ff) begin
         area_mem[s1_col_ff] <= area_now;
         sq_mem[s1_col_ff]   <= sq_now;
      end
   end

endmodule

>>> rtl/integral_image_with_squares_core.sv
// Top level of the integral image block with squared sums.
// Instantiates iiws_front, iiws_fifo (two) and iiws_back; uses iiws_pkg.
//
//   channel  direction  handshake             word
//   req      in         push / full           pixel
//   rsp      out        empty / pop           area_sum, square_sum, frame_end
//   csr      in         csr_write_en          csr_index, csr_data
//
// One pixel per clock while full is low; a result passes through both queues.
// The back part reads the line store (one read, one write port) on each issue.
// Reset clears counters, row sums and queues; the line store is not cleared.
// A stalled result side fills the result queue, then the inner queue, then full.
module integral_image_with_squares_core import iiws_pkg::*; #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]      csr_data,
   input  logic                   push,
   output logic                   full,
   input  logic [PIXEL_W-1:0]     req_pixel,
   output logic                   empty,
   input  logic                   pop,
   output logic [AREA_W-1:0]      rsp_area_sum,
   output logic [SQUARE_W-1:0]    rsp_square_sum,
   output logic                   rsp_frame_end
);

   localparam int ColW  = $clog2(MAX_WIDTH);
   localparam int WorkW = $bits(work_type);
   localparam int ResW  = $bits(result_type);

   logic                  front_push, q_full, q_empty, q_pop;
   logic [ColW-1:0]       front_col, q_col;
   work_type              front_work, q_work;
   logic [ColW+WorkW-1:0] q_data;
   logic                  out_push, out_full;
   logic [QCOUNT_W-1:0]   out_count;
   result_type            back_result, out_result;
   logic [ResW-1:0]       out_data;

   iiws_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .push         (push),
      .pixel        (req_pixel),
      .queue_full   (q_full),
      .queue_push   (front_push),
      .work_col     (front_col),
      .work         (front_work)
   );

   iiws_fifo #(.WIDTH(ColW + WorkW), .DEPTH(QUEUE_DEPTH)) u_work_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .data_in  ({front_col, front_work}),
      .pop      (q_pop),
      .data_out (q_data),
      .full     (q_full),
      .empty    (q_empty),
      .count    ()
   );

   assign q_col  = q_data[ColW+WorkW-1:WorkW];
   assign q_work = work_type'(q_data[WorkW-1:0]);

   iiws_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (q_empty),
      .queue_col   (q_col),
      .queue_work  (q_work),
      .queue_pop   (q_pop),
      .out_count   (out_count),
      .out_push    (out_push),
      .out_data    (back_result)
   );

   iiws_fifo #(.WIDTH(ResW), .DEPTH(QUEUE_DEPTH)) u_result_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (out_push),
      .data_in  (back_result),
      .pop      (pop),
      .data_out (out_data),
      .full     (out_full),
      .empty    (empty),
      .count    (out_count)
   );

   assign out_result     = result_type'(out_data);
   assign full           = q_full;
   assign rsp_area_sum   = out_result.area_sum;
   assign rsp_square_sum = out_result.square_sum;
   assign rsp_frame_end  = out_result.frame_end;

   a_result_room: assert property (@(posedge clock) disable iff (reset)
      !(out_push && out_full))
      else $error("result queue overflow");

   a_pop_needs_room: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (out_count != QCOUNT_W'(QUEUE_DEPTH)))
      else $error("word issued with no result room");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

endmodule
